// ----- design/glpf_pkg.sv -----
// ----------------------------------------------------------------------------
// glpf_pkg
// shared types and codes of the grid local peak finder
// ----------------------------------------------------------------------------
`default_nettype none

package glpf_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int COORD_W    = 5;
  localparam int CNT_W      = 6;
  localparam int FLAG_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int FRAME_LIM  = 32;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  // one peak report
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ----- design/grid_local_peak_finder_unit.sv -----
// ----------------------------------------------------------------------------
// grid_local_peak_finder_unit
// streaming four-neighbour local maximum detector over a raster frame
// ----------------------------------------------------------------------------
// usage:
//   samples enter in row-major order on in_valid/in_ready. a sample in an
//   inner row is judged when the sample below it arrives; a result request
//   (peak_row, peak_col, last_of_run) leaves on out_valid/out_ready.
//   peaks of the last row are collected as flags and sent in column order
//   after the frame's final sample. last_of_run marks the final result
//   caused by one sample; a sample that completes no peak sends nothing.
//   frame_width / frame_height are written on the cfg port (index 0 / 1),
//   only while the unit is idle; any such write restarts the frame.
// timing:
//   a sample is accepted only in idle and takes six steps on the single
//   read port of the row store (five neighbour reads, then a wait on the
//   registered read) and an evaluate step that writes it back. a peak of
//   the row above adds an emit step; the final sample adds the flag
//   walk. a result shows on the outputs the cycle after it is produced.
// reset and stall:
//   rst (sync, active high) returns to row 0, column 0 with flags cleared and
//   width and height 1; the row store is not cleared, no stale entry is used.
//   when the receiver stalls, the
//   result waits in the output register and the sequencer holds at its next
//   result until the slot frees; input is accepted meanwhile only in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_local_peak_finder_unit #(
  parameter int MAX_WIDTH   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // sample channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [glpf_pkg::SAMPLE_W-1:0]   sample_value,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [glpf_pkg::COORD_W-1:0]     peak_row,
  output logic [glpf_pkg::COORD_W-1:0]     peak_col,
  output logic                             last_of_run,
  // config channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [glpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [glpf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import glpf_pkg::*;

  localparam int DEPTH = 2 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int W_LIM = (MAX_WIDTH < FRAME_LIM) ? MAX_WIDTH : FRAME_LIM;
  localparam int SB    = SAMPLE_BITS;

  typedef logic signed [SB-1:0] smp_t;

  function automatic logic is_peak(smp_t ctr, smp_t up, smp_t dn, smp_t lf, smp_t rt);
    return (ctr >= up) && (ctr >= dn) && (ctr >= lf) && (ctr >= rt);
  endfunction

  // config registers and effective frame size
  logic [CNT_W-1:0] frame_width;
  logic [CNT_W-1:0] frame_height;
  logic [CNT_W-1:0] eff_w;
  logic [CNT_W-1:0] eff_h;

  always_comb begin
    eff_w = (frame_width == '0) ? CNT_W'(1) : frame_width;
    if (eff_w > CNT_W'(W_LIM)) begin
      eff_w = CNT_W'(W_LIM);
    end
    eff_h = (frame_height == '0) ? CNT_W'(1) : frame_height;
    if (eff_h > CNT_W'(FRAME_LIM)) begin
      eff_h = CNT_W'(FRAME_LIM);
    end
  end

  // incoming sample at internal width
  smp_t x_in;

  generate
    if (SB <= SAMPLE_W) begin : g_narrow
      assign x_in = sample_value[SB-1:0];
    end else begin : g_wide
      // field bits are taken as is, the upper bits stay zero
      assign x_in = {{(SB-SAMPLE_W){1'b0}}, sample_value};
    end
  endgenerate

  // sequencer state
  state_t state;
  state_t state_next;

  logic [2:0]         step;         // read step 0..5
  logic [CNT_W-1:0]   row_count;
  logic [CNT_W-1:0]   col_count;
  logic [CNT_W-1:0]   r;            // position of the sample in work
  logic [CNT_W-1:0]   c;
  smp_t               x;
  smp_t               left_sample;
  logic [FLAG_W-1:0]  flags;
  logic               final_item;
  logic [COORD_W-1:0] k;            // flag walk column

  // neighbour captures
  smp_t a_prv_c;    // row above, same column
  smp_t b_cur_c;    // two rows above, same column
  smp_t c_prv_l;    // row above, left column
  smp_t d_prv_r;    // row above, right column
  smp_t e_cur_ll;   // this row, two columns left

  // memory port
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  smp_t          rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // addresses of the two banks, banked by row parity
  logic [7:0] cur_base;
  logic [7:0] prv_base;
  logic [7:0] c8;
  logic       has_left;
  logic       has_left2;
  logic       has_right;

  assign cur_base  = r[0] ? 8'(MAX_WIDTH) : 8'd0;
  assign prv_base  = r[0] ? 8'd0 : 8'(MAX_WIDTH);
  assign c8        = {2'b00, c};
  assign has_left  = (c >= CNT_W'(1));
  assign has_left2 = (c >= CNT_W'(2));
  assign has_right = ({1'b0, c} + 7'd1) < {1'b0, eff_w};

  always_comb begin
    case (step)
      3'd0:    rd_addr = AW'(prv_base + c8);
      3'd1:    rd_addr = AW'(cur_base + c8);
      3'd2:    rd_addr = has_left  ? AW'(prv_base + c8 - 8'd1) : '0;
      3'd3:    rd_addr = has_right ? AW'(prv_base + c8 + 8'd1) : '0;
      3'd4:    rd_addr = has_left2 ? AW'(cur_base + c8 - 8'd2) : '0;
      default: rd_addr = '0;
    endcase
  end

  assign wr_addr = AW'(cur_base + c8);

  glpf_row_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (SB),
    .AW     (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (x)
  );

  // peak tests, all from registered values
  smp_t              zero_s;
  logic              last_row;
  logic              is_final;
  logic              peak_above_w;
  logic              left_flag;
  logic              self_flag;
  logic [FLAG_W-1:0] flags_new;

  assign zero_s   = '0;
  assign last_row = (r == eff_h - CNT_W'(1));
  assign is_final = last_row && (c == eff_w - CNT_W'(1));

  always_comb begin
    // row above judged against this sample as its lower neighbour
    peak_above_w = (r != '0) &&
                   is_peak(a_prv_c, (r >= CNT_W'(2)) ? b_cur_c : zero_s, x,
                           has_left ? c_prv_l : zero_s,
                           has_right ? d_prv_r : zero_s);
    // last row: left neighbour now has its right side
    left_flag = last_row && has_left &&
                is_peak(left_sample, (r != '0) ? c_prv_l : zero_s, zero_s,
                        has_left2 ? e_cur_ll : zero_s, x);
    // last sample of the frame: its right side is outside
    self_flag = is_final &&
                is_peak(x, (r != '0) ? a_prv_c : zero_s, zero_s,
                        has_left ? left_sample : zero_s, zero_s);
    flags_new = flags;
    if (left_flag) begin
      flags_new[c[COORD_W-1:0] - COORD_W'(1)] = 1'b1;
    end
    if (self_flag) begin
      flags_new[c[COORD_W-1:0]] = 1'b1;
    end
  end

  // result requests
  logic    out_free;
  logic    push;
  result_t push_data;
  logic    flag_k;
  logic    k_end;
  logic    flags_above_k;

  assign flag_k        = flags[k];
  assign k_end         = ({1'b0, k} == eff_w - CNT_W'(1));
  assign flags_above_k = (flags >> ({1'b0, k} + CNT_W'(1))) != '0;

  // control
  logic in_acc;
  logic cfg_acc;

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    push       = 1'b0;
    push_data  = '0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en = (step < 3'd5);
        if (step == 3'd5) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        wr_en = 1'b1;
        if (peak_above_w) begin
          state_next = ST_EMIT;
        end else if (is_final) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        push_data.row  = COORD_W'(r - CNT_W'(1));
        push_data.col  = c[COORD_W-1:0];
        push_data.last = !(final_item && (flags != '0));
        if (out_free) begin
          push       = 1'b1;
          state_next = final_item ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        push_data.row  = r[COORD_W-1:0];
        push_data.col  = k;
        push_data.last = !flags_above_k;
        if (!flag_k || out_free) begin
          push = flag_k;
          if (k_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  logic restart_pos;

  assign restart_pos = (row_count >= eff_h) || (col_count >= eff_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CNT_W'(1);
      frame_height <= CNT_W'(1);
      row_count    <= '0;
      col_count    <= '0;
      left_sample  <= '0;
      flags        <= '0;
      step         <= '0;
      k            <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_width <= cfg_data;
            row_count   <= '0;
            col_count   <= '0;
            left_sample <= '0;
            flags       <= '0;
          end
          REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data;
            row_count    <= '0;
            col_count    <= '0;
            left_sample  <= '0;
            flags        <= '0;
          end
          default: begin
          end
        endcase
      end
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (in_acc && restart_pos) begin
            left_sample <= '0;
            flags       <= '0;
          end
        end
        ST_READ: begin
          step <= step + 3'd1;
        end
        ST_EVAL: begin
          flags <= flags_new;
          k     <= '0;
          if (is_final) begin
            row_count   <= '0;
            col_count   <= '0;
            left_sample <= '0;
          end else begin
            left_sample <= x;
            if (c + CNT_W'(1) >= eff_w) begin
              col_count <= '0;
              row_count <= r + CNT_W'(1);
            end else begin
              col_count <= c + CNT_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!flag_k || out_free) begin
            if (k_end) begin
              flags <= '0;
            end else begin
              k <= k + COORD_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x <= x_in;
      r <= restart_pos ? '0 : row_count;
      c <= restart_pos ? '0 : col_count;
    end
    if (state == ST_EVAL) begin
      final_item <= is_final;
    end
    if (state == ST_READ) begin
      case (step)
        3'd1:    a_prv_c  <= rd_data;
        3'd2:    b_cur_c  <= rd_data;
        3'd3:    c_prv_l  <= rd_data;
        3'd4:    d_prv_r  <= rd_data;
        3'd5:    e_cur_ll <= rd_data;
        default: begin
        end
      endcase
    end
  end

  glpf_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data   (push_data),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .peak_row    (peak_row),
    .peak_col    (peak_col),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ----- design/glpf_row_mem.sv -----
// ----------------------------------------------------------------------------
// glpf_row_mem
// two-bank row store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module glpf_row_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 16,
  parameter int AW     = 6
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/glpf_out_stage.sv -----
// ----------------------------------------------------------------------------
// glpf_out_stage
// result register between the sequencer and the downstream receiver
// ----------------------------------------------------------------------------
`default_nettype none

module glpf_out_stage (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire glpf_pkg::result_t        push_data,
  output logic                          free,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [glpf_pkg::COORD_W-1:0]  peak_row,
  output logic [glpf_pkg::COORD_W-1:0]  peak_col,
  output logic                          last_of_run
);

  import glpf_pkg::*;

  result_t held;

  // slot can take a new request when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_data;
    end
  end

  assign peak_row    = held.row;
  assign peak_col    = held.col;
  assign last_of_run = held.last;

endmodule

`default_nettype wire
